/* src/tts_pkg.sv */
package tts_pkg;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_CODE   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } tts_state_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic       scrolled;
    } tts_result_t;

endpackage

/* src/tts_screen_mem.sv */
module tts_screen_mem #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_q [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_q[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_q[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/tts_ctrl.sv */
module tts_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [7:0]            s_char_code,
    input  logic [10:0]           s_cell_index,
    input  logic [7:0]            attr,
    output logic                  res_valid,
    input  logic                  res_ready,
    output tts_pkg::tts_result_t  res,
    output logic                  mem_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0] mem_waddr,
    output logic [15:0]           mem_wdata,
    output logic                  mem_re,
    output logic [$clog2(ROWS*COLUMNS)-1:0] mem_raddr,
    input  logic [15:0]           mem_rdata
);
    import tts_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);

    tts_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              hit_reg, hit_next;
    logic [7:0]        char_reg, char_next;
    logic [7:0]        attr_reg, attr_next;
    logic              scrolled_reg, scrolled_next;
    logic              wrap;
    logic [15:0]       blank;

    assign blank = {attr, BLANK_CODE};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            base_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg      <= hit_next;
        char_reg     <= char_next;
        attr_reg     <= attr_next;
        scrolled_reg <= scrolled_next;
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        base_next     = base_reg;
        hit_next      = hit_reg;
        char_next     = char_reg;
        attr_next     = attr_reg;
        scrolled_next = scrolled_reg;
        s_ready       = 1'b0;
        res_valid     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        wrap          = 1'b0;

        unique case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = {RESET_ATTR, BLANK_CODE};
                if (cnt_reg == CNT_W'(CELL_COUNT - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    char_next     = '0;
                    attr_next     = '0;
                    scrolled_next = 1'b0;
                    hit_next      = 1'b0;
                    cnt_next      = '0;
                    unique case (s_kind)
                        KIND_PUT: begin
                            if (s_char_code == NEWLINE_CODE) begin
                                col_next = '0;
                                wrap     = 1'b1;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = base_reg + ADDR_W'(col_reg);
                                mem_wdata = {attr, s_char_code};
                                if (col_reg == COL_W'(COLUMNS - 1)) begin
                                    col_next = '0;
                                    wrap     = 1'b1;
                                end else begin
                                    col_next = col_reg + COL_W'(1);
                                end
                            end
                            if (wrap && row_reg == ROW_W'(ROWS - 1)) begin
                                scrolled_next = 1'b1;
                                state_next    = ST_COPY;
                            end else if (wrap) begin
                                row_next   = row_reg + ROW_W'(1);
                                base_next  = base_reg + ADDR_W'(COLUMNS);
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        KIND_CLEAR: begin
                            row_next   = '0;
                            col_next   = '0;
                            base_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        KIND_READ: begin
                            mem_re     = 1'b1;
                            mem_raddr  = ADDR_W'(s_cell_index);
                            hit_next   = 32'(s_cell_index) < CELL_COUNT;
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                char_next  = hit_reg ? mem_rdata[7:0] : 8'd0;
                attr_next  = hit_reg ? mem_rdata[15:8] : 8'd0;
                state_next = ST_DONE;
            end
            ST_COPY: begin
                if (cnt_reg < CNT_W'(MOVE_COUNT)) begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg[ADDR_W-1:0] + ADDR_W'(COLUMNS);
                end
                if (cnt_reg != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg[ADDR_W-1:0] - ADDR_W'(1);
                    mem_wdata = mem_rdata;
                end
                if (cnt_reg == CNT_W'(MOVE_COUNT)) begin
                    state_next = ST_FILL;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FILL, ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = blank;
                if (cnt_reg == CNT_W'(CELL_COUNT - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.cell_char  = char_reg;
    assign res.cell_attr  = attr_reg;
    assign res.cursor_row = 5'(row_reg);
    assign res.cursor_col = 7'(col_reg);
    assign res.scrolled   = scrolled_reg;

endmodule

/* src/text_terminal_with_scroll_unit.sv */
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_kind, s_char_code, s_cell_index
// m_        out        m_valid / m_ready   m_cell_char, m_cell_attr, m_cursor_row,
//                                          m_cursor_col, m_scrolled
// cfg       in         APB (pready high)   fg_color at 0x0, bg_color at 0x4
//
// A clear writes every cell, and a put that scrolls copies each row up and then blanks the last row.
// Both passes go one cell at a time through the screen memory's one write port.
// After reset a blanking pass over all ROWS*COLUMNS cells runs before the first item.
// An output register holds a result while the next item is accepted.
// A stalled m_ready holds the result and stops the next one at its end.
module text_terminal_with_scroll_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_char_code,
    input  logic [10:0] s_cell_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_cell_char,
    output logic [7:0]  m_cell_attr,
    output logic [4:0]  m_cursor_row,
    output logic [6:0]  m_cursor_col,
    output logic        m_scrolled,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tts_pkg::*;

    localparam int ADDR_W = $clog2(ROWS * COLUMNS);

    logic [3:0]        fg_reg;
    logic [3:0]        bg_reg;
    logic              res_valid;
    logic              res_ready;
    tts_result_t       res;
    tts_result_t       out_reg;
    logic              out_valid_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= 4'd7;
            bg_reg <= 4'd0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_FG: fg_reg <= pwdata[3:0];
                REG_BG: bg_reg <= pwdata[3:0];
                default: fg_reg <= fg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FG:  prdata = {28'd0, fg_reg};
            REG_BG:  prdata = {28'd0, bg_reg};
            default: prdata = '0;
        endcase
    end

    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_cell_char  = out_reg.cell_char;
    assign m_cell_attr  = out_reg.cell_attr;
    assign m_cursor_row = out_reg.cursor_row;
    assign m_cursor_col = out_reg.cursor_col;
    assign m_scrolled   = out_reg.scrolled;

    tts_ctrl #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_char_code (s_char_code),
        .s_cell_index(s_cell_index),
        .attr        ({bg_reg, fg_reg}),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    tts_screen_mem #(
        .DEPTH (ROWS * COLUMNS),
        .ADDR_W(ADDR_W),
        .DATA_W(16)
    ) u_mem (
        .aclk   (aclk),
        .wr_en  (mem_we),
        .wr_addr(mem_waddr),
        .wr_data(mem_wdata),
        .rd_en  (mem_re),
        .rd_addr(mem_raddr),
        .rd_data(mem_rdata)
    );

endmodule

/* src/tts_checker.sv */
module tts_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_cell_char,
    input logic [7:0] m_cell_attr,
    input logic [4:0] m_cursor_row,
    input logic [6:0] m_cursor_col,
    input logic       m_scrolled,
    input logic       pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_char) && $stable(m_cell_attr)
            && $stable(m_cursor_row) && $stable(m_cursor_col) && $stable(m_scrolled))
        else $error("result changed while stalled");

    a_scroll_no_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scrolled |-> m_cell_char == 8'd0 && m_cell_attr == 8'd0)
        else $error("scrolling item carries cell data");

    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scrolled |-> m_cursor_row == 5'(ROWS - 1))
        else $error("scroll left cursor off last row");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_cursor_col) < COLUMNS)
        else $error("cursor column out of range");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind text_terminal_with_scroll_unit tts_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tts_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import tts_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = ROWS * COLUMNS;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int MAX_REPORTS = 100;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam tts_result_t RES_ZERO = '0;
    localparam tts_result_t RES_BLANK_HOME = {BLANK_CODE, RESET_ATTR, 5'd0, 7'd0, 1'b0};

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [10:0] idx;
        logic [7:0]  reps;
        logic        typed;
        tts_result_t res;
    } dir_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = KIND_PUT;
    logic [7:0]  s_char_code = 8'd0;
    logic [10:0] s_cell_index = 11'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_cell_char;
    logic [7:0]  m_cell_attr;
    logic [4:0]  m_cursor_row;
    logic [6:0]  m_cursor_col;
    logic        m_scrolled;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    logic [15:0] screen_img [CELLS];
    int          cur_row;
    int          cur_col;
    logic [3:0]  fg_reg;
    logic [3:0]  bg_reg;
    tts_result_t screen_replies [$];
    tts_result_t want;
    dir_row_t    dir_rows [23];

    int mismatch_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    text_terminal_with_scroll_unit #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_char_code(s_char_code),
        .s_cell_index(s_cell_index),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_cell_char(m_cell_char),
        .m_cell_attr(m_cell_attr),
        .m_cursor_row(m_cursor_row),
        .m_cursor_col(m_cursor_col),
        .m_scrolled(m_scrolled),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $time);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (screen_replies.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                want = screen_replies.pop_front();
                if (m_cell_char !== want.cell_char)
                    report_mismatch("cell_char", m_cell_char, want.cell_char);
                if (m_cell_attr !== want.cell_attr)
                    report_mismatch("cell_attr", m_cell_attr, want.cell_attr);
                if (m_cursor_row !== want.cursor_row)
                    report_mismatch("cursor_row", m_cursor_row, want.cursor_row);
                if (m_cursor_col !== want.cursor_col)
                    report_mismatch("cursor_col", m_cursor_col, want.cursor_col);
                if (m_scrolled !== want.scrolled)
                    report_mismatch("scrolled", m_scrolled, want.scrolled);
            end
        end
    end

    task automatic step_screen(input logic [1:0] kind, input logic [7:0] ch,
                               input logic [10:0] idx, output tts_result_t res);
        logic [7:0] attr;
        int pos;
        attr = {bg_reg, fg_reg};
        res = '0;
        case (kind)
            KIND_PUT: begin
                if (ch == NEWLINE_CODE) begin
                    cur_col = 0;
                    cur_row++;
                end else begin
                    pos = cur_row * COLUMNS + cur_col;
                    if (pos < CELLS)
                        screen_img[pos] = {attr, ch};
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_img[i] = screen_img[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_img[i] = {attr, BLANK_CODE};
                    cur_row = ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_img[i] = {attr, BLANK_CODE};
                cur_row = 0;
                cur_col = 0;
            end
            KIND_READ: begin
                if (idx < CELLS)
                    {res.cell_attr, res.cell_char} = screen_img[idx];
            end
            default: begin
            end
        endcase
        res.cursor_row = cur_row[4:0];
        res.cursor_col = cur_col[6:0];
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [10:0] idx, input logic typed,
                             input tts_result_t typed_res);
        tts_result_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_char_code <= ch;
        s_cell_index <= idx;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        step_screen(kind, ch, idx, res);
        screen_replies.push_back(typed ? typed_res : res);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (screen_replies.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_color_reg(input logic sel, input logic [3:0] value);
        logic [31:0] wdata;
        wdata = $urandom();
        wdata[3:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_FG)
            fg_reg = value;
        else
            bg_reg = value;
        @(posedge aclk);
    endtask

    task automatic run_directed();
        dir_rows = '{
            {KIND_READ, 8'h00, 11'd0, 8'd1, 1'b1, RES_BLANK_HOME},
            {KIND_READ, 8'hFF, 11'd1999, 8'd1, 1'b1, RES_BLANK_HOME},
            {KIND_READ, 8'h00, 11'd2000, 8'd1, 1'b1, RES_ZERO},
            {KIND_READ, 8'h55, 11'd2047, 8'd1, 1'b1, RES_ZERO},
            {KIND_UNUSED, 8'hFF, 11'h7FF, 8'd1, 1'b1, RES_ZERO},
            {KIND_CLEAR, 8'hAA, 11'h555, 8'd1, 1'b1, RES_ZERO},
            {KIND_READ, 8'h00, 11'd1000, 8'd1, 1'b1, RES_BLANK_HOME},
            {KIND_PUT, 8'h41, 11'h2AA, 8'd1, 1'b1, 8'h00, 8'h00, 5'd0, 7'd1, 1'b0},
            {KIND_PUT, 8'hFF, 11'd0, 8'd1, 1'b0, RES_ZERO},
            {KIND_PUT, 8'h00, 11'h7FF, 8'd1, 1'b0, RES_ZERO},
            {KIND_READ, 8'h00, 11'd0, 8'd1, 1'b1, 8'h41, RESET_ATTR, 5'd0, 7'd3, 1'b0},
            {KIND_PUT, NEWLINE_CODE, 11'd0, 8'd1, 1'b1, 8'h00, 8'h00, 5'd1, 7'd0, 1'b0},
            {KIND_PUT, 8'h42, 11'd0, 8'd79, 1'b0, RES_ZERO},
            {KIND_PUT, 8'h43, 11'd0, 8'd1, 1'b0, RES_ZERO},
            {KIND_READ, 8'h00, 11'd159, 8'd1, 1'b0, RES_ZERO},
            {KIND_PUT, NEWLINE_CODE, 11'd0, 8'd22, 1'b0, RES_ZERO},
            {KIND_PUT, 8'h5A, 11'd0, 8'd1, 1'b0, RES_ZERO},
            {KIND_PUT, NEWLINE_CODE, 11'd0, 8'd1, 1'b0, RES_ZERO},
            {KIND_READ, 8'h00, 11'd1920, 8'd1, 1'b0, RES_ZERO},
            {KIND_READ, 8'h00, 11'd1840, 8'd1, 1'b0, RES_ZERO},
            {KIND_READ, 8'h00, 11'd0, 8'd1, 1'b0, RES_ZERO},
            {KIND_UNUSED, 8'h00, 11'd0, 8'd1, 1'b0, RES_ZERO},
            {KIND_READ, 8'h00, 11'd1999, 8'd1, 1'b0, RES_ZERO}
        };
        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++)
                send_item(dir_rows[r].kind, dir_rows[r].ch, dir_rows[r].idx,
                          dir_rows[r].typed, dir_rows[r].res);
        end
    endtask

    task automatic run_random(input int count, input int nl_pct);
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [10:0] idx;
        int          pick;
        int          here;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(999);
            ch = 8'($urandom_range(255));
            idx = 11'($urandom_range(2047));
            if (pick < 10) begin
                kind = KIND_CLEAR;
            end else if (pick < 30) begin
                kind = KIND_UNUSED;
            end else if (pick < 200) begin
                kind = KIND_READ;
                pick = $urandom_range(9);
                if (pick < 5) begin
                    here = cur_row * COLUMNS + cur_col - $urandom_range(1, 2 * COLUMNS);
                    idx = (here < 0) ? 11'd0 : here[10:0];
                end else if (pick < 9) begin
                    idx = 11'($urandom_range(CELLS - 1));
                end else begin
                    idx = 11'($urandom_range(2047, CELLS));
                end
            end else begin
                kind = KIND_PUT;
                if ($urandom_range(99) < nl_pct)
                    ch = NEWLINE_CODE;
            end
            send_item(kind, ch, idx, 1'b0, RES_ZERO);
            if (n % 50 == 49) begin
                wait_for_results();
                write_color_reg(REG_FG, 4'($urandom_range(15)));
                write_color_reg(REG_BG, 4'($urandom_range(15)));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++)
            screen_img[i] = {RESET_ATTR, BLANK_CODE};
        cur_row = 0;
        cur_col = 0;
        fg_reg = 4'd7;
        bg_reg = 4'd0;
        src_idle_pct = 7;
        sink_idle_pct = 69;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        wait_for_results();
        write_color_reg(REG_FG, 4'hF);
        write_color_reg(REG_BG, 4'hF);
        run_random(93, 8);

        wait_for_results();
        src_idle_pct = 69;
        sink_idle_pct = 7;
        write_color_reg(REG_FG, 4'h0);
        write_color_reg(REG_BG, 4'h0);
        run_random(93, 1);

        wait_for_results();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        write_color_reg(REG_FG, 4'($urandom_range(15)));
        write_color_reg(REG_BG, 4'($urandom_range(15)));
        // hold the receiver off while items keep coming
        hold_token++;
        run_random(92, 4);

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && screen_replies.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
src/tts_pkg.sv
src/tts_screen_mem.sv
src/tts_ctrl.sv
src/text_terminal_with_scroll_unit.sv
src/tts_checker.sv
tb/tb.sv
